@@ rtl/core/tbsr_pkg.sv @@
`default_nettype none

package tbsr_pkg;

    localparam int WINDOW = 64;
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int IDX_W  = 64;
    localparam int CNT_W  = 7;
    localparam int BYTE_W = 8;

    // Operand set for the shared adder: y = a + (inv ? ~b : b) + cin.
    typedef struct packed {
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic             inv;
        logic             cin;
    } t_alu_req;

    typedef struct packed {
        logic [IDX_W-1:0] sum;
        logic             cout;
    } t_alu_rsp;

    // Write and clear controls for the window store and its filled marks.
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              clr;
        logic [SLOT_W-1:0] caddr;
    } t_win_ctl;

endpackage

`default_nettype wire

@@ rtl/core/tbsr_alu.sv @@
`default_nettype none

module tbsr_alu (
    input  wire tbsr_pkg::t_alu_req i_req,
    output tbsr_pkg::t_alu_rsp      o_rsp
);

    logic [tbsr_pkg::IDX_W-1:0] w_b;
    logic [tbsr_pkg::IDX_W:0]   w_full;

    assign w_b    = i_req.inv ? ~i_req.b : i_req.b;
    assign w_full = {1'b0, i_req.a} + {1'b0, w_b}
                    + {{tbsr_pkg::IDX_W{1'b0}}, i_req.cin};

    assign o_rsp.sum  = w_full[tbsr_pkg::IDX_W-1:0];
    assign o_rsp.cout = w_full[tbsr_pkg::IDX_W];

endmodule

`default_nettype wire

@@ rtl/core/tbsr_window.sv @@
`default_nettype none

module tbsr_window (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire tbsr_pkg::t_win_ctl          i_ctl,
    input  wire [tbsr_pkg::SLOT_W-1:0]       i_raddr,
    output logic [tbsr_pkg::BYTE_W-1:0]      o_rdata,
    output logic [tbsr_pkg::WINDOW-1:0]      o_marks
);

    logic [tbsr_pkg::BYTE_W-1:0] r_mem [tbsr_pkg::WINDOW];
    logic [tbsr_pkg::BYTE_W-1:0] r_rdata;
    logic [tbsr_pkg::WINDOW-1:0] r_marks;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks <= '0;
        end else begin
            if (i_ctl.clr) begin
                r_marks[i_ctl.caddr] <= 1'b0;
            end
            if (i_ctl.we) begin
                r_marks[i_ctl.waddr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rdata;
    assign o_marks = r_marks;

endmodule

`default_nettype wire

@@ rtl/core/tcp_byte_stream_reassembler.sv @@
`default_nettype none

// Byte-stream reassembler. Each request carries one segment byte (or marks an
// empty segment) and is taken when start is high and busy is low. A request
// without segment end only passes the store step; a segment end adds the end
// index step on a final segment, setup and a release step per released byte.
// The release walks the window one entry per cycle through the store, which
// has a write port and a registered read port, and one 64-bit adder is shared
// by every index compare and the end index sum. Results appear one per cycle
// on the o_ ports, each marked by o_strobe for exactly one cycle, in the cycle
// after the work that makes them; the receiver cannot stall, so it must take
// every result then. The last result of a release carries o_run_last, and a
// release of nothing gives one status result with o_out_valid low.

module tcp_byte_stream_reassembler (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire [tbsr_pkg::IDX_W-1:0]         i_stream_index,
    input  wire [tbsr_pkg::BYTE_W-1:0]        i_data_byte,
    input  wire                               i_byte_present,
    input  wire                               i_segment_end,
    input  wire                               i_final_segment,
    input  wire [tbsr_pkg::CNT_W-1:0]         i_free_space,
    output logic                              o_strobe,
    output logic [tbsr_pkg::BYTE_W-1:0]       o_out_byte,
    output logic                              o_out_valid,
    output logic                              o_run_last,
    output logic [tbsr_pkg::CNT_W-1:0]        o_bytes_waiting,
    output logic                              o_stream_closed
);

    localparam int SW = tbsr_pkg::SLOT_W;
    localparam int CW = tbsr_pkg::CNT_W;
    localparam int IW = tbsr_pkg::IDX_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_STORE = 3'd1;
    localparam logic [2:0] ST_ENDIX = 3'd2;
    localparam logic [2:0] ST_SETUP = 3'd3;
    localparam logic [2:0] ST_REL   = 3'd4;

    localparam logic [CW-1:0] WIN_CNT  = CW'(tbsr_pkg::WINDOW);
    localparam logic [SW:0]   WIN_SUM  = (SW+1)'(tbsr_pkg::WINDOW);
    localparam logic [SW-1:0] LAST_SLT = SW'(tbsr_pkg::WINDOW - 1);

    logic [2:0]                   r_state, n_state;
    logic [IW-1:0]                r_idx;
    logic [tbsr_pkg::BYTE_W-1:0]  r_byte;
    logic                         r_present;
    logic                         r_seg_end;
    logic                         r_final;
    logic [CW-1:0]                r_free;

    logic [IW-1:0]                r_next, n_next;
    logic [IW-1:0]                r_next1, n_next1;
    logic [SW-1:0]                r_next_slot, n_next_slot;
    logic [CW-1:0]                r_pending, n_pending;
    logic                         r_end_known, n_end_known;
    logic [IW-1:0]                r_end, n_end;
    logic                         r_closed, n_closed;

    logic                         r_strobe, n_strobe;
    logic [tbsr_pkg::BYTE_W-1:0]  r_out_byte, n_out_byte;
    logic                         r_out_valid, n_out_valid;
    logic                         r_run_last, n_run_last;

    tbsr_pkg::t_alu_req           w_req;
    tbsr_pkg::t_alu_rsp           w_rsp;
    tbsr_pkg::t_win_ctl           w_ctl;
    logic [tbsr_pkg::BYTE_W-1:0]  w_rdata;
    logic [tbsr_pkg::WINDOW-1:0]  w_marks;

    logic                         w_accept;
    logic [CW-1:0]                w_limit;
    logic                         w_in_win;
    logic [SW:0]                  w_slot_sum;
    logic [SW-1:0]                w_wslot;
    logic [SW-1:0]                w_slot_inc;

    assign w_accept = start && !busy;
    assign busy     = (r_state != ST_IDLE);

    tbsr_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    tbsr_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_raddr (n_next_slot),
        .o_rdata (w_rdata),
        .o_marks (w_marks)
    );

    // Operand selection for the shared adder.
    always_comb begin
        w_req = '0;
        unique case (r_state)
            ST_STORE: begin
                w_req.a   = r_idx;
                w_req.b   = r_next;
                w_req.inv = 1'b1;
                w_req.cin = 1'b1;
            end
            ST_ENDIX: begin
                w_req.a   = r_idx;
                w_req.b   = '0;
                w_req.inv = 1'b0;
                w_req.cin = r_present;
            end
            ST_REL: begin
                w_req.a   = r_next1;
                w_req.b   = r_end;
                w_req.inv = 1'b1;
                w_req.cin = 1'b1;
            end
            default: begin
                w_req.a   = r_next;
                w_req.b   = r_end;
                w_req.inv = 1'b1;
                w_req.cin = 1'b1;
            end
        endcase
    end

    // The offset from the next undelivered index is below the window, so the
    // slot is the next slot plus that offset with at most one wrap.
    assign w_limit    = (r_free > WIN_CNT) ? WIN_CNT : r_free;
    assign w_in_win   = w_rsp.cout && (w_rsp.sum[IW-1:CW] == '0)
                        && (w_rsp.sum[CW-1:0] < w_limit);
    assign w_slot_sum = {1'b0, r_next_slot} + {1'b0, w_rsp.sum[SW-1:0]};
    assign w_wslot    = (w_slot_sum >= WIN_SUM) ? SW'(w_slot_sum - WIN_SUM)
                                                : w_slot_sum[SW-1:0];
    assign w_slot_inc = (r_next_slot == LAST_SLT) ? '0 : r_next_slot + SW'(1);

    always_comb begin
        n_state     = r_state;
        n_next      = r_next;
        n_next1     = r_next1;
        n_next_slot = r_next_slot;
        n_pending   = r_pending;
        n_end_known = r_end_known;
        n_end       = r_end;
        n_closed    = r_closed;
        n_strobe    = 1'b0;
        n_out_byte  = r_out_byte;
        n_out_valid = r_out_valid;
        n_run_last  = r_run_last;
        w_ctl       = '0;
        w_ctl.waddr = w_wslot;
        w_ctl.wdata = r_byte;
        w_ctl.caddr = r_next_slot;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                if (r_present && w_in_win) begin
                    w_ctl.we = 1'b1;
                    if (!w_marks[w_wslot] && (r_pending < WIN_CNT)) begin
                        n_pending = r_pending + CW'(1);
                    end
                end
                if (!r_seg_end) begin
                    n_state = ST_IDLE;
                end else if (r_final) begin
                    n_state = ST_ENDIX;
                end else begin
                    n_state = ST_SETUP;
                end
            end
            ST_ENDIX: begin
                n_end_known = 1'b1;
                n_end       = w_rsp.sum;
                n_state     = ST_SETUP;
            end
            ST_SETUP: begin
                n_closed = r_closed || (r_end_known && w_rsp.cout);
                if (w_marks[r_next_slot]) begin
                    n_state = ST_REL;
                end else begin
                    n_strobe    = 1'b1;
                    n_out_byte  = '0;
                    n_out_valid = 1'b0;
                    n_run_last  = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_REL: begin
                w_ctl.clr   = 1'b1;
                n_next      = r_next1;
                n_next1     = r_next1 + IW'(1);
                n_next_slot = w_slot_inc;
                if (r_pending != '0) begin
                    n_pending = r_pending - CW'(1);
                end
                n_closed    = r_closed || (r_end_known && w_rsp.cout);
                n_strobe    = 1'b1;
                n_out_byte  = w_rdata;
                n_out_valid = 1'b1;
                n_run_last  = !w_marks[w_slot_inc];
                if (!w_marks[w_slot_inc]) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx     <= i_stream_index;
            r_byte    <= i_data_byte;
            r_present <= i_byte_present;
            r_seg_end <= i_segment_end;
            r_final   <= i_final_segment;
            r_free    <= i_free_space;
        end
        r_out_byte  <= n_out_byte;
        r_out_valid <= n_out_valid;
        r_run_last  <= n_run_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_next      <= '0;
            r_next1     <= IW'(1);
            r_next_slot <= '0;
            r_pending   <= '0;
            r_end_known <= 1'b0;
            r_end       <= '0;
            r_closed    <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next      <= n_next;
            r_next1     <= n_next1;
            r_next_slot <= n_next_slot;
            r_pending   <= n_pending;
            r_end_known <= n_end_known;
            r_end       <= n_end;
            r_closed    <= n_closed;
            r_strobe    <= n_strobe;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_out_byte      = r_out_byte;
    assign o_out_valid     = r_out_valid;
    assign o_run_last      = r_run_last;
    assign o_bytes_waiting = r_pending;
    assign o_stream_closed = r_closed;

    // A release only ever delivers an entry that holds a byte.
    a_rel_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REL) |-> w_marks[r_next_slot])
        else $error("release of an empty window entry");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_out_valid) |-> o_run_last)
        else $error("status result without run end");

    a_closed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_closed |=> r_closed)
        else $error("closed flag dropped");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= WIN_CNT)
        else $error("waiting count beyond window");

    a_next1_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next1 == r_next + IW'(1))
        else $error("next index pair out of step");

endmodule

`default_nettype wire

@@ tb/tcp_byte_stream_reassembler_test.sv @@
`default_nettype none

module tcp_byte_stream_reassembler_test;

    localparam int WINDOW = tbsr_pkg::WINDOW;
    localparam int IDX_W  = tbsr_pkg::IDX_W;
    localparam int CNT_W  = tbsr_pkg::CNT_W;
    localparam int BYTE_W = tbsr_pkg::BYTE_W;

    localparam int REQUEST_TARGET = 480;
    localparam int CLOSE_AT       = 430;
    localparam int IDLE_LIMIT     = 2000;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [BYTE_W-1:0] data;
        logic              present;
        logic              seg_end;
        logic              final_seg;
        logic [CNT_W-1:0]  free;
    } t_seg_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              valid;
        logic              last;
        logic [CNT_W-1:0]  waiting;
        logic              closed;
    } t_release;

    class stream_scoreboard;
        logic [BYTE_W-1:0] store [WINDOW];
        bit                filled [WINDOW];
        logic [IDX_W-1:0]  next_idx;
        int                pending;
        bit                end_known;
        logic [IDX_W-1:0]  end_idx;
        bit                closed;
        t_release          expected_q [$];
        int                errors;
        int                data_results;
        int                status_results;

        function new();
            foreach (filled[i]) begin
                filled[i] = 1'b0;
                store[i]  = '0;
            end
            next_idx       = '0;
            pending        = 0;
            end_known      = 1'b0;
            end_idx        = '0;
            closed         = 1'b0;
            errors         = 0;
            data_results   = 0;
            status_results = 0;
        endfunction

        function void update_close();
            if (end_known && next_idx >= end_idx)
                closed = 1'b1;
        endfunction

        // Stores the byte of an accepted request and, on a segment end, queues the
        // bytes that the release will deliver.
        function void note_request(t_seg_item it);
            logic [IDX_W-1:0] lim;
            logic [IDX_W-1:0] ahead;
            int               slot;
            int               n;
            t_release         r;
            lim   = (it.free < WINDOW) ? IDX_W'(it.free) : IDX_W'(WINDOW);
            ahead = it.index - next_idx;
            if (it.present && it.index >= next_idx && ahead < lim) begin
                slot = int'(it.index % IDX_W'(WINDOW));
                if (!filled[slot] && pending < WINDOW)
                    pending++;
                store[slot]  = it.data;
                filled[slot] = 1'b1;
            end
            if (!it.seg_end)
                return;
            if (it.final_seg) begin
                end_known = 1'b1;
                end_idx   = it.present ? it.index + IDX_W'(1) : it.index;
            end
            update_close();
            n = 0;
            while (n < WINDOW) begin
                slot = int'(next_idx % IDX_W'(WINDOW));
                if (!filled[slot])
                    break;
                filled[slot] = 1'b0;
                next_idx++;
                if (pending > 0)
                    pending--;
                update_close();
                r.data    = store[slot];
                r.valid   = 1'b1;
                r.last    = (n == WINDOW - 1) || !filled[int'(next_idx % IDX_W'(WINDOW))];
                r.waiting = pending[CNT_W-1:0];
                r.closed  = closed;
                expected_q.push_back(r);
                n++;
            end
            if (n == 0) begin
                r.data    = '0;
                r.valid   = 1'b0;
                r.last    = 1'b1;
                r.waiting = pending[CNT_W-1:0];
                r.closed  = closed;
                expected_q.push_back(r);
            end
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_release got);
            t_release want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual byte %0h valid %0b",
                         $time, got.data, got.valid);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("out_byte", want.data, got.data);
            compare_field("out_valid", 8'(want.valid), 8'(got.valid));
            compare_field("run_last", 8'(want.last), 8'(got.last));
            compare_field("bytes_waiting", 8'(want.waiting), 8'(got.waiting));
            compare_field("stream_closed", 8'(want.closed), 8'(got.closed));
            if (want.valid)
                data_results++;
            else
                status_results++;
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [IDX_W-1:0]  i_stream_index = '0;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic              i_byte_present = 1'b0;
    logic              i_segment_end = 1'b0;
    logic              i_final_segment = 1'b0;
    logic [CNT_W-1:0]  i_free_space = '0;
    logic              o_strobe;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_out_valid;
    logic              o_run_last;
    logic [CNT_W-1:0]  o_bytes_waiting;
    logic              o_stream_closed;

    stream_scoreboard sb;
    int               requests_sent = 0;
    int               idle_cycles = 0;
    bit               no_gaps = 1'b0;

    tcp_byte_stream_reassembler DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_stream_index  (i_stream_index),
        .i_data_byte     (i_data_byte),
        .i_byte_present  (i_byte_present),
        .i_segment_end   (i_segment_end),
        .i_final_segment (i_final_segment),
        .i_free_space    (i_free_space),
        .o_strobe        (o_strobe),
        .o_out_byte      (o_out_byte),
        .o_out_valid     (o_out_valid),
        .o_run_last      (o_run_last),
        .o_bytes_waiting (o_bytes_waiting),
        .o_stream_closed (o_stream_closed)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Outputs and handshake signals only change at the rising edge, so the
    // falling edge sees the values that the next rising edge will accept.
    always @(negedge i_clk) begin
        t_release got;
        if (i_rst_n) begin
            if (o_strobe === 1'b1) begin
                got = {o_out_byte, o_out_valid, o_run_last, o_bytes_waiting, o_stream_closed};
                sb.check_result(got);
            end
            if (o_strobe === 1'b1 || (start && busy === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: timeout with %0d results still expected", $time,
                         sb.expected_q.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Called at a rising edge; returns at the rising edge that accepts the request.
    task automatic drive_request(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] data,
                                 input bit present, input bit seg_end, input bit final_seg,
                                 input logic [CNT_W-1:0] free);
        t_seg_item it;
        int        gap;
        it  = {idx, data, present, seg_end, final_seg, free};
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_stream_index  <= idx;
        i_data_byte     <= data;
        i_byte_present  <= present;
        i_segment_end   <= seg_end;
        i_final_segment <= final_seg;
        i_free_space    <= free;
        @(negedge i_clk);
        while (busy !== 1'b0) begin
            @(posedge i_clk);
            @(negedge i_clk);
        end
        sb.note_request(it);
        requests_sent++;
        @(posedge i_clk);
    endtask

    task automatic send_segment(input logic [IDX_W-1:0] base, input int len, input bit shuffled,
                                input bit is_final, input bit vary_free);
        logic [IDX_W-1:0] pos [$];
        logic [IDX_W-1:0] tmp;
        int               j;
        for (int i = 0; i < len; i++)
            pos.push_back(base + IDX_W'(i));
        if (shuffled) begin
            for (int i = len - 1; i > 0; i--) begin
                j      = $urandom_range(0, i);
                tmp    = pos[i];
                pos[i] = pos[j];
                pos[j] = tmp;
            end
        end
        for (int i = 0; i < len; i++)
            drive_request(pos[i], BYTE_W'($urandom_range(0, 255)), 1'b1, i == len - 1,
                          is_final && i == len - 1,
                          vary_free ? CNT_W'($urandom_range(0, 64)) : CNT_W'(64));
    endtask

    initial begin
        int               kind;
        int               off;
        int               len;
        int               k;
        bit               close_done;
        logic [IDX_W-1:0] base;
        sb         = new();
        close_done = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty segment, out-of-order and duplicate bytes, free space
        // limits, late and far bytes, final flags and indexes at the top of the range.
        no_gaps = 1'b1;
        drive_request(64'd0, 8'h00, 1'b0, 1'b1, 1'b0, 7'd64);
        drive_request(64'd1, 8'hA5, 1'b1, 1'b0, 1'b0, 7'd64);
        drive_request(64'd1, 8'h5A, 1'b1, 1'b0, 1'b0, 7'd64);
        drive_request(64'd0, 8'hFF, 1'b1, 1'b1, 1'b0, 7'd1);
        drive_request(64'd1, 8'h11, 1'b1, 1'b1, 1'b0, 7'd64);
        drive_request(64'd2, 8'h00, 1'b1, 1'b1, 1'b0, 7'd0);
        no_gaps = 1'b0;
        drive_request(64'd66, 8'h77, 1'b1, 1'b0, 1'b0, 7'd64);
        drive_request(64'd65, 8'h33, 1'b1, 1'b0, 1'b0, 7'd64);
        drive_request('1, 8'h80, 1'b1, 1'b1, 1'b0, 7'd64);
        drive_request(64'd3, 8'hC3, 1'b1, 1'b0, 1'b1, 7'd64);
        drive_request(64'd2, 8'h3C, 1'b1, 1'b1, 1'b0, 7'd63);
        drive_request(64'd4, 8'h00, 1'b0, 1'b0, 1'b1, 7'd64);
        drive_request('1, 8'h00, 1'b0, 1'b1, 1'b1, 7'd64);
        drive_request(64'hFFFF_FFFF_FFFF_FFFE, 8'hFE, 1'b1, 1'b1, 1'b1, 7'd64);
        drive_request(64'hAAAA_5555_AAAA_5555, 8'h55, 1'b1, 1'b0, 1'b0, 7'd64);
        drive_request(64'h5555_AAAA_5555_AAAA, 8'hAA, 1'b1, 1'b1, 1'b0, 7'd33);

        while (requests_sent < REQUEST_TARGET) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            base    = sb.next_idx;
            if (!close_done && requests_sent >= CLOSE_AT) begin
                // A final segment that leaves a hole, then the byte that fills it.
                send_segment(base + 1, 3, 1'b0, 1'b1, 1'b0);
                send_segment(base, 1, 1'b0, 1'b0, 1'b0);
                close_done = 1'b1;
                continue;
            end
            kind = $urandom_range(0, 99);
            if (kind < 57) begin
                k = $urandom_range(0, 9);
                off = (k < 5) ? 0 : (k < 8) ? $urandom_range(1, 8) : $urandom_range(9, 60);
                len = $urandom_range(1, 6);
                send_segment(base + off, len, $urandom_range(0, 3) == 0, 1'b0,
                             $urandom_range(0, 6) == 0);
            end else if (kind < 64) begin
                k = $urandom_range(1, 4);
                if (base >= k)
                    send_segment(base - k, k + $urandom_range(1, 5), 1'($urandom_range(0, 1)),
                                 1'b0, 1'b0);
                else
                    send_segment(base, $urandom_range(1, 5), 1'b0, 1'b0, 1'b0);
            end else if (kind < 67) begin
                send_segment(base, $urandom_range(48, 64), 1'($urandom_range(0, 1)), 1'b0,
                             1'b0);
            end else if (kind < 77) begin
                drive_request(base + $urandom_range(0, 70), BYTE_W'($urandom_range(0, 255)),
                              1'b0, 1'b1, 1'b0, CNT_W'($urandom_range(0, 64)));
            end else if (kind < 81) begin
                // Empty final segment far ahead: records an end index without closing.
                drive_request({$urandom_range(1, 32'hFFFF_FFFF), $urandom},
                              BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1, 7'd64);
            end else begin
                k = int'($urandom_range(0, 3) == 0);
                drive_request({$urandom, $urandom}, BYTE_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'(k),
                              (k != 0) ? 1'b0 : 1'($urandom_range(0, 1)),
                              CNT_W'($urandom_range(0, 64)));
            end
        end
        // After close: a final byte at the top index, whose end index wraps to zero.
        drive_request('1, 8'h01, 1'b1, 1'b1, 1'b1, 7'd64);
        start <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Drove %0d requests; checked %0d delivered bytes and %0d status results.",
                 requests_sent, sb.data_results, sb.status_results);
        $display("Stream reached index %0d and was %0s at the end.", sb.next_idx,
                 sb.closed ? "closed" : "open");
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
